FILE: rtl/core/scb_pkg.sv
`timescale 1ns / 1ps
package scb_pkg;

   localparam int DEF_MAX_CHUNKS  = 4096;
   localparam int DEF_MAX_SAMPLES = 65536;

   localparam int POS_W        = 48;
   localparam int SIZE_W       = 31;
   localparam int CHUNK_OUT_W  = 13;
   localparam int RUN_CNT_W    = 17;
   localparam int SAMPLE_OUT_W = 17;
   localparam int SUM_W        = 47;
   localparam int OFFSET32_W   = 32;
   localparam int RUN_PAIR     = 2;

   localparam int REQ_DATA_W = 128;
   localparam int RSP_DATA_W = 112;

   localparam logic [RUN_CNT_W-1:0] RUN_CNT_MAX = {RUN_CNT_W{1'b1}};
   localparam logic [SUM_W-1:0]     SUM_MAX     = {SUM_W{1'b1}};

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic exec;
   } dp_cmd_type;

   typedef struct packed {
      logic out_blocked;
   } dp_status_type;

endpackage

FILE: rtl/core/scb_ctrl.sv
`timescale 1ns / 1ps
module scb_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  scb_pkg::dp_status_type status,
   output scb_pkg::dp_cmd_type    cmd
);
   import scb_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // wait here while the result register still holds an untaken word
            if (!status.out_blocked) begin
               cmd.exec = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/core/scb_datapath.sv
`timescale 1ns / 1ps
module scb_datapath #(
   parameter int MAX_CHUNKS  = scb_pkg::DEF_MAX_CHUNKS,
   parameter int MAX_SAMPLES = scb_pkg::DEF_MAX_SAMPLES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  scb_pkg::dp_cmd_type              cmd,
   output scb_pkg::dp_status_type           status,
   input  logic [scb_pkg::POS_W-1:0]        sample_position,
   input  logic [scb_pkg::POS_W-1:0]        previous_end,
   input  logic [scb_pkg::SIZE_W-1:0]       sample_size,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [scb_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import scb_pkg::*;

   localparam int CCW       = $clog2(MAX_CHUNKS + 1);
   localparam int CAW       = $clog2(MAX_CHUNKS);
   localparam int SCW       = $clog2(MAX_SAMPLES + 1);
   localparam int SAW       = $clog2(MAX_SAMPLES);
   localparam int SUM_EXT_W = SUM_W + 1;

   // tables
   logic [POS_W-1:0]     chunk_mem     [MAX_CHUNKS];
   logic [CCW-1:0]       run_first_mem [MAX_CHUNKS];
   logic [RUN_CNT_W-1:0] run_cnt_mem   [MAX_CHUNKS];
   logic [SIZE_W-1:0]    size_mem      [MAX_SAMPLES];

   // latched input word
   logic [POS_W-1:0]  pos_ff;
   logic [POS_W-1:0]  prev_pos_ff;
   logic [SIZE_W-1:0] size_ff;

   // counters and flags
   logic [CCW-1:0]       cc_ff, cc_in;
   logic [CCW-1:0]       rc_ff, rc_in;
   logic [RUN_CNT_W-1:0] last_ff, last_in;
   logic [RUN_CNT_W-1:0] prev_ff, prev_in;
   logic [SCW-1:0]       sc_ff, sc_in;
   logic [SIZE_W-1:0]    lsize_ff, lsize_in;
   logic                 same_ff, same_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic                 wide_ff, wide_in;
   logic                 ovf_ff, ovf_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                 new_chunk;
   logic                 drop;
   logic [CCW-1:0]       rc_dec;
   logic [CCW-1:0]       rc_mid;
   logic                 chunk_we;
   logic                 first_we;
   logic                 cnt_we;
   logic [CAW-1:0]       cnt_waddr;
   logic [RUN_CNT_W-1:0] cnt_wdata;
   logic                 size_we;
   logic [SUM_EXT_W-1:0] sum_add;
   logic [RUN_CNT_W-1:0] last_out;

   assign rc_dec  = rc_ff - CCW'(1);
   assign sum_add = {1'b0, sum_ff} + SUM_EXT_W'(size_ff);

   always_comb begin
      cc_in     = cc_ff;
      rc_in     = rc_ff;
      last_in   = last_ff;
      prev_in   = prev_ff;
      sc_in     = sc_ff;
      lsize_in  = lsize_ff;
      same_in   = same_ff;
      sum_in    = sum_ff;
      wide_in   = wide_ff;
      ovf_in    = ovf_ff;
      new_chunk = 1'b0;
      drop      = 1'b0;
      rc_mid    = rc_ff;
      chunk_we  = 1'b0;
      first_we  = 1'b0;
      cnt_we    = 1'b0;
      cnt_waddr = rc_dec[CAW-1:0];
      cnt_wdata = last_ff;
      size_we   = 1'b0;
      if (cmd.exec) begin
         if (pos_ff == prev_pos_ff && rc_ff != '0) begin
            // sample continues the current chunk
            if (last_ff != RUN_CNT_MAX) begin
               last_in = last_ff + RUN_CNT_W'(1);
            end
            cnt_we    = 1'b1;
            cnt_wdata = last_in;
         end else begin
            new_chunk = 1'b1;
            if (pos_ff[POS_W-1:OFFSET32_W] != '0) begin
               wide_in = 1'b1;
            end
            if (cc_ff == CCW'(MAX_CHUNKS)) begin
               ovf_in = 1'b1;
            end else begin
               chunk_we = 1'b1;
               cc_in    = cc_ff + CCW'(1);
               drop     = (rc_ff >= CCW'(RUN_PAIR)) && (last_ff == prev_ff);
               rc_mid   = drop ? rc_dec : rc_ff;
               if (rc_mid == CCW'(MAX_CHUNKS)) begin
                  ovf_in = 1'b1;
                  rc_in  = rc_mid;
                  if (drop) begin
                     last_in = prev_ff;
                  end
               end else begin
                  first_we  = 1'b1;
                  cnt_we    = 1'b1;
                  cnt_waddr = rc_mid[CAW-1:0];
                  cnt_wdata = RUN_CNT_W'(1);
                  rc_in     = rc_mid + CCW'(1);
                  last_in   = RUN_CNT_W'(1);
                  if (!drop) begin
                     prev_in = last_ff;
                  end
               end
            end
         end

         // size bookkeeping
         sum_in = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
         if (same_ff && sc_ff != '0 && lsize_ff != size_ff) begin
            same_in = 1'b0;
         end
         if (sc_ff == SCW'(MAX_SAMPLES)) begin
            ovf_in = 1'b1;
         end else begin
            size_we  = 1'b1;
            sc_in    = sc_ff + SCW'(1);
            lsize_in = size_ff;
         end
      end
   end

   assign last_out = (rc_in != '0) ? last_in : '0;

   always_comb begin
      rsp_data_in = {1'b0, ovf_in, wide_in, sum_in, same_in,
                     SAMPLE_OUT_W'(sc_in), last_out,
                     CHUNK_OUT_W'(rc_in), CHUNK_OUT_W'(cc_in), new_chunk};
      if (cmd.exec) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cc_ff        <= '0;
         rc_ff        <= '0;
         last_ff      <= '0;
         prev_ff      <= '0;
         sc_ff        <= '0;
         lsize_ff     <= '0;
         same_ff      <= 1'b1;
         sum_ff       <= '0;
         wide_ff      <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cc_ff        <= cc_in;
         rc_ff        <= rc_in;
         last_ff      <= last_in;
         prev_ff      <= prev_in;
         sc_ff        <= sc_in;
         lsize_ff     <= lsize_in;
         same_ff      <= same_in;
         sum_ff       <= sum_in;
         wide_ff      <= wide_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pos_ff      <= sample_position;
         prev_pos_ff <= previous_end;
         size_ff     <= sample_size;
      end
      if (cmd.exec) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (chunk_we) begin
         chunk_mem[cc_ff[CAW-1:0]] <= pos_ff;
      end
      if (first_we) begin
         run_first_mem[rc_mid[CAW-1:0]] <= cc_in;
      end
      if (cnt_we) begin
         run_cnt_mem[cnt_waddr] <= cnt_wdata;
      end
      if (size_we) begin
         size_mem[sc_ff[SAW-1:0]] <= size_ff;
      end
   end

   assign status.out_blocked = rsp_valid_ff && !rsp_tready;
   assign rsp_tvalid         = rsp_valid_ff;
   assign rsp_tdata          = rsp_data_ff;

endmodule

FILE: rtl/core/sample_chunk_table_builder.sv
`timescale 1ns / 1ps
// Sample and chunk table builder for a media file track.
// Input channel req_*: one word per written sample (position, previous end
// position, size). Result channel rsp_*: exactly one word per sample with
// the new-chunk mark, table counts, running byte total and sticky flags.
// Chunk offsets, sample-to-chunk runs and sample sizes are kept in internal
// tables; a full table drops the append and raises the overflow flag.
// A word accepted in the idle state is loaded into the input registers;
// its result is registered in the update state once the result register
// is free or being taken. Words are handled one at a time: the controller
// captures a word, then updates the tables and the last run entry.
// The result register lets the next word be captured while a result waits.
// Receiver stall: a held result keeps rsp_tdata stable; a second finished
// word waits in the update state and req_tready stays low until it moves.
// Reset (synchronous): counters, byte total and flags clear, the uniform
// flag sets, rsp_tvalid drops. Table contents are not cleared; only entries
// below their counts are meaningful, so no clearing pass is needed.
module sample_chunk_table_builder #(
   parameter int MAX_CHUNKS  = scb_pkg::DEF_MAX_CHUNKS,
   parameter int MAX_SAMPLES = scb_pkg::DEF_MAX_SAMPLES
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // sample_position[47:0], previous_end[95:48], sample_size[126:96], pad
   input  logic [scb_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // new_chunk[0], chunk_total[13:1], run_entries[26:14],
   // samples_in_chunk[43:27], sample_total[60:44], uniform_size[61],
   // bytes_total[108:62], wide_offsets[109], table_overflow[110], pad
   output logic [scb_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import scb_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   scb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   scb_datapath #(
      .MAX_CHUNKS  (MAX_CHUNKS),
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .sample_position (req_tdata[POS_W-1:0]),
      .previous_end    (req_tdata[2*POS_W-1:POS_W]),
      .sample_size     (req_tdata[2*POS_W+SIZE_W-1:2*POS_W]),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata)
   );

endmodule

FILE: rtl/core/scb_checker.sv
`timescale 1ns / 1ps
module scb_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [scb_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import scb_pkg::*;

   localparam int WIDE_BIT = 109;

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   a_one_word_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second word accepted while one is being updated");

   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("result word without an accepted input word");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result word changed");

   a_wide_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[WIDE_BIT] |=> !rsp_tvalid || rsp_tdata[WIDE_BIT])
      else $error("wide offset flag cleared");

endmodule

bind sample_chunk_table_builder scb_checker u_scb_checker (.*);

FILE: tb/tb.sv
`timescale 1ns / 1ps
module tb;
   import scb_pkg::*;

   localparam int MAX_CHUNKS  = DEF_MAX_CHUNKS;
   localparam int MAX_SAMPLES = DEF_MAX_SAMPLES;
   localparam int CYCLE_LIMIT = 3_000_000;
   localparam logic [POS_W-1:0] OFFSET32_MAX = 48'h0000_FFFF_FFFF;
   localparam logic [POS_W-1:0] POS_MAX      = {POS_W{1'b1}};
   localparam logic [SIZE_W-1:0] SIZE_MAX    = {SIZE_W{1'b1}};

   typedef struct packed {
      logic                    new_chunk;
      logic [CHUNK_OUT_W-1:0]  chunk_total;
      logic [CHUNK_OUT_W-1:0]  run_entries;
      logic [RUN_CNT_W-1:0]    samples_in_chunk;
      logic [SAMPLE_OUT_W-1:0] sample_total;
      logic                    uniform_size;
      logic [SUM_W-1:0]        bytes_total;
      logic                    wide_offsets;
      logic                    table_overflow;
   } track_status_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   sample_chunk_table_builder uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // predicted track state
   int unsigned        n_chunks;
   int unsigned        n_runs;
   int unsigned        n_sizes;
   int unsigned        run_len [MAX_CHUNKS];
   logic [SIZE_W-1:0]  prev_size;
   logic               same_size;
   logic [SUM_W-1:0]   byte_sum;
   logic               wide_seen;
   logic               overflow_seen;

   track_status_type   pending_status [$];
   logic [POS_W-1:0]   write_end;
   int                 req_idle_pct;
   int                 rsp_idle_pct;
   int                 errors;
   int                 words_seen;
   int                 cycles;

   function automatic track_status_type record_sample(input logic [POS_W-1:0] pos,
                                                      input logic [POS_W-1:0] prev,
                                                      input logic [SIZE_W-1:0] size);
      track_status_type s;
      s.new_chunk = 1'b1;
      if (pos == prev && n_runs > 0) begin
         if (run_len[n_runs-1] < 32'(RUN_CNT_MAX))
            run_len[n_runs-1]++;
         s.new_chunk = 1'b0;
      end else begin
         if (pos > OFFSET32_MAX)
            wide_seen = 1'b1;
         if (n_chunks >= MAX_CHUNKS) begin
            overflow_seen = 1'b1;
         end else begin
            n_chunks++;
            if (n_runs >= RUN_PAIR && run_len[n_runs-1] == run_len[n_runs-RUN_PAIR])
               n_runs--;
            if (n_runs >= MAX_CHUNKS) begin
               overflow_seen = 1'b1;
            end else begin
               run_len[n_runs] = 1;
               n_runs++;
            end
         end
      end
      if (byte_sum > SUM_MAX - SUM_W'(size))
         byte_sum = SUM_MAX;
      else
         byte_sum = byte_sum + SUM_W'(size);
      if (same_size && n_sizes > 0 && prev_size != size)
         same_size = 1'b0;
      if (n_sizes >= MAX_SAMPLES) begin
         overflow_seen = 1'b1;
      end else begin
         n_sizes++;
         prev_size = size;
      end
      s.chunk_total      = n_chunks[CHUNK_OUT_W-1:0];
      s.run_entries      = n_runs[CHUNK_OUT_W-1:0];
      s.samples_in_chunk = (n_runs > 0) ? run_len[n_runs-1][RUN_CNT_W-1:0] : '0;
      s.sample_total     = n_sizes[SAMPLE_OUT_W-1:0];
      s.uniform_size     = same_size;
      s.bytes_total      = byte_sum;
      s.wide_offsets     = wide_seen;
      s.table_overflow   = overflow_seen;
      return s;
   endfunction

   function automatic logic [POS_W-1:0] rand_pos();
      case ($urandom_range(3))
         0: return POS_W'($urandom_range(16'hFFFF));
         1: return POS_W'($urandom);
         2: return OFFSET32_MAX - POS_W'(8) + POS_W'($urandom_range(16));
         default: return {16'($urandom), 32'($urandom)};
      endcase
   endfunction

   function automatic logic [SIZE_W-1:0] rand_size();
      case ($urandom_range(3))
         0: return SIZE_W'($urandom_range(255));
         1: return SIZE_W'($urandom);
         2: return SIZE_MAX - SIZE_W'($urandom_range(3));
         default: return SIZE_W'($urandom_range(65535));
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (errors < 50)
         $display("%0t word %0d: %s got %0h expected %0h", $time, words_seen, what, got, want);
      errors++;
   endtask

   // req_tvalid is left high after a word; stop_req lowers it
   task automatic send_sample(input logic [POS_W-1:0] pos, input logic [POS_W-1:0] prev,
                              input logic [SIZE_W-1:0] size);
      if ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < req_idle_pct)
            @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, size, prev, pos};
      do @(posedge clock); while (!req_tready);
      pending_status.push_back(record_sample(pos, prev, size));
   endtask

   task automatic stop_req();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain_results();
      stop_req();
      while (pending_status.size() != 0)
         @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   always @(posedge clock) begin : check_rsp
      track_status_type got;
      track_status_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         words_seen++;
         got.new_chunk        = rsp_tdata[0];
         got.chunk_total      = rsp_tdata[13:1];
         got.run_entries      = rsp_tdata[26:14];
         got.samples_in_chunk = rsp_tdata[43:27];
         got.sample_total     = rsp_tdata[60:44];
         got.uniform_size     = rsp_tdata[61];
         got.bytes_total      = rsp_tdata[108:62];
         got.wide_offsets     = rsp_tdata[109];
         got.table_overflow   = rsp_tdata[110];
         if (pending_status.size() == 0) begin
            report_mismatch("unexpected word", '0, '0);
         end else begin
            want = pending_status.pop_front();
            if (got.new_chunk !== want.new_chunk)
               report_mismatch("new_chunk", 64'(got.new_chunk), 64'(want.new_chunk));
            if (got.chunk_total !== want.chunk_total)
               report_mismatch("chunk_total", 64'(got.chunk_total), 64'(want.chunk_total));
            if (got.run_entries !== want.run_entries)
               report_mismatch("run_entries", 64'(got.run_entries), 64'(want.run_entries));
            if (got.samples_in_chunk !== want.samples_in_chunk)
               report_mismatch("samples_in_chunk", 64'(got.samples_in_chunk),
                               64'(want.samples_in_chunk));
            if (got.sample_total !== want.sample_total)
               report_mismatch("sample_total", 64'(got.sample_total),
                               64'(want.sample_total));
            if (got.uniform_size !== want.uniform_size)
               report_mismatch("uniform_size", 64'(got.uniform_size),
                               64'(want.uniform_size));
            if (got.bytes_total !== want.bytes_total)
               report_mismatch("bytes_total", 64'(got.bytes_total), 64'(want.bytes_total));
            if (got.wide_offsets !== want.wide_offsets)
               report_mismatch("wide_offsets", 64'(got.wide_offsets),
                               64'(want.wide_offsets));
            if (got.table_overflow !== want.table_overflow)
               report_mismatch("table_overflow", 64'(got.table_overflow),
                               64'(want.table_overflow));
         end
      end
   end

   task automatic test_directed();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      // first word with position == previous end still opens a chunk
      send_sample('0, '0, '0);
      send_sample('0, '0, '0);
      send_sample(48'h1000, '0, '0);
      send_sample(48'h1000, 48'h1000, '0);
      // last two runs equal: the last one is replaced
      send_sample(48'h2000, 48'h5, '0);
      send_sample(OFFSET32_MAX, '0, 31'd7);
      send_sample(OFFSET32_MAX + 1, '0, 31'd7);
      send_sample(POS_MAX, POS_MAX, SIZE_MAX);
      send_sample('0, POS_MAX, SIZE_MAX);
      send_sample(POS_MAX, '0, 31'd1);
      send_sample(48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 31'h5555_5555);
      send_sample(48'h5555_5555_5555, 48'h5555_5555_5555, 31'h2AAA_AAAA);
      send_sample(48'h3000, 48'h3001, 31'd1);
      send_sample(48'h4000, 48'h4001, 31'd1);
      send_sample(48'h5000, 48'h5001, 31'd1);
      send_sample(48'h5000, 48'h5000, 31'd1);
      send_sample(48'h6000, 48'h6001, SIZE_MAX);
      write_end = 48'h6000 + POS_W'(SIZE_MAX);
      drain_results();
   endtask

   task automatic test_random_flow(input int req_pct, input int rsp_pct, input int n_items);
      int               sent;
      int               run_goal;
      int               k;
      logic [POS_W-1:0] start;
      logic [POS_W-1:0] pos;
      logic [SIZE_W-1:0] sz;
      req_idle_pct = req_pct;
      rsp_idle_pct = rsp_pct;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(9) == 0) begin
            send_sample(rand_pos(), rand_pos(), rand_size());
            sent++;
         end else begin
            run_goal = ($urandom_range(7) == 0) ? $urandom_range(30, 6) : $urandom_range(4, 1);
            start = rand_pos();
            if (start == write_end)
               start = start + POS_W'(1);
            for (k = 0; k < run_goal; k++) begin
               sz  = rand_size();
               pos = (k == 0) ? start : write_end;
               send_sample(pos, write_end, sz);
               write_end = pos + POS_W'(sz);
               sent++;
            end
         end
      end
      drain_results();
   endtask

   // one long continuing run of large samples, broken by a few new chunks
   task automatic test_long_run();
      int               n;
      logic [POS_W-1:0] pos;
      logic [SIZE_W-1:0] sz;
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      for (n = 0; n < 120; n++) begin
         sz = ($urandom_range(15) == 0) ? rand_size()
                                        : SIZE_W'($urandom_range(32'h7FFF_FFFF, 32'h4000_0000));
         if (n % 50 == 0)
            pos = write_end + POS_W'(1) + POS_W'($urandom_range(4095));
         else
            pos = write_end;
         send_sample(pos, write_end, sz);
         write_end = pos + POS_W'(sz);
      end
      drain_results();
   endtask

   initial begin
      n_chunks      = 0;
      n_runs        = 0;
      n_sizes       = 0;
      prev_size     = '0;
      same_size     = 1'b1;
      byte_sum      = '0;
      wide_seen     = 1'b0;
      overflow_seen = 1'b0;
      write_end     = '0;
      req_idle_pct  = 0;
      rsp_idle_pct  = 0;
      errors        = 0;
      words_seen    = 0;
      cycles        = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_flow(32, 83, 520);
      test_random_flow(83, 32, 520);
      test_random_flow(0, 0, 520);
      test_long_run();
      repeat (10) @(posedge clock);
      if (errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
